// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// File: hw/rtl/ffiga_pkg.sv
`default_nettype none
package ffiga_pkg;

   localparam int POOL_COUNT        = 2;
   localparam int INDEX_WIDTH       = 7;
   localparam int COUNT_WIDTH       = 16;
   localparam int DEF_MAX_RESOURCES = 64;
   localparam int DEF_TIME_WIDTH    = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   typedef struct packed {
      logic valid;
      logic pool;
      logic done;
   } ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/ffiga_cell.sv
`default_nettype none
module ffiga_cell
   import ffiga_pkg::*;
#(
   parameter int TIME_WIDTH = DEF_TIME_WIDTH,
   parameter int SLOT_WIDTH = 7,
   parameter int SLOT_NUM   = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire ctl_type                in_ctl,
   input  wire logic [TIME_WIDTH-1:0]  in_start,
   input  wire logic [TIME_WIDTH-1:0]  in_stop,
   input  wire logic [SLOT_WIDTH-1:0]  in_slot,
   input  wire logic [COUNT_WIDTH-1:0] in_count,
   output ctl_type                     out_ctl,
   output logic [TIME_WIDTH-1:0]       out_start,
   output logic [TIME_WIDTH-1:0]       out_stop,
   output logic [SLOT_WIDTH-1:0]       out_slot,
   output logic [COUNT_WIDTH-1:0]      out_count,
   output logic [POOL_COUNT-1:0]       open_o
);

   logic [POOL_COUNT-1:0]  open_ff, open_in;
   logic [TIME_WIDTH-1:0]  end_ff    [POOL_COUNT];
   logic [COUNT_WIDTH-1:0] served_ff [POOL_COUNT];
   ctl_type                ctl_ff, ctl_in;
   logic [TIME_WIDTH-1:0]  start_ff, stop_ff;
   logic [SLOT_WIDTH-1:0]  slot_ff, slot_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   is_open, hit, write_en;
   logic [COUNT_WIDTH-1:0] next_count;

   always_comb begin
      is_open = open_ff[in_ctl.pool];
      hit     = in_ctl.valid && !in_ctl.done &&
                (!is_open || (in_start > end_ff[in_ctl.pool]));
      if (!is_open) begin
         next_count = COUNT_ONE;
      end else if (served_ff[in_ctl.pool] == COUNT_MAX) begin
         next_count = COUNT_MAX;
      end else begin
         next_count = served_ff[in_ctl.pool] + COUNT_ONE;
      end
      write_en = advance && hit;
      open_in  = open_ff;
      if (write_en) begin
         open_in[in_ctl.pool] = 1'b1;
      end
      ctl_in      = in_ctl;
      ctl_in.done = in_ctl.done || hit;
      slot_in     = hit ? SLOT_WIDTH'(SLOT_NUM) : in_slot;
      count_in    = hit ? next_count : in_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= '0;
         ctl_ff.valid <= 1'b0;
      end else begin
         open_ff <= open_in;
         if (advance) begin
            ctl_ff <= ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff    <= in_start;
         stop_ff     <= in_stop;
         slot_ff     <= slot_in;
         count_ff    <= count_in;
      end
      if (write_en) begin
         end_ff[in_ctl.pool]    <= in_stop;
         served_ff[in_ctl.pool] <= next_count;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_start = start_ff;
   assign out_stop  = stop_ff;
   assign out_slot  = slot_ff;
   assign out_count = count_ff;
   assign open_o    = open_ff;

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_interval_gate_allocator.sv
// A request passes through the chain of cells, each registering it, on its way to the result.
// Throughput: one request per cycle; the chain stalls as a whole while a result waits.
// The last cell's register is the output register; the request side is ready when it is
// empty or being taken, outside reset.
// Reset (synchronous, active high) closes every resource in both pools and empties the chain.
`default_nettype none
`include "assert_macros.svh"
module first_fit_interval_gate_allocator
   import ffiga_pkg::*;
#(
   parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
   parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_pool_select,
   input  wire logic [31:0]            req_start_time,
   input  wire logic [31:0]            req_end_time,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [INDEX_WIDTH-1:0]      rsp_assigned_index,
   output logic [COUNT_WIDTH-1:0]      rsp_served_count,
   output logic                        rsp_pool_full
);

   localparam int SLOT_WIDTH = $clog2(MAX_RESOURCES + 1);

   ctl_type                chain_ctl   [MAX_RESOURCES+1];
   logic [TIME_WIDTH-1:0]  chain_start [MAX_RESOURCES+1];
   logic [TIME_WIDTH-1:0]  chain_stop  [MAX_RESOURCES+1];
   logic [SLOT_WIDTH-1:0]  chain_slot  [MAX_RESOURCES+1];
   logic [COUNT_WIDTH-1:0] chain_count [MAX_RESOURCES+1];
   logic [MAX_RESOURCES-1:0] open_pool0, open_pool1;
   logic                   advance;
   ctl_type                tail;

   assign tail    = chain_ctl[MAX_RESOURCES];
   assign advance = !tail.valid || rsp_ready;

   assign chain_ctl[0]   = ctl_type'{valid: req_valid, pool: req_pool_select, done: 1'b0};
   assign chain_start[0] = TIME_WIDTH'(req_start_time);
   assign chain_stop[0]  = TIME_WIDTH'(req_end_time);
   assign chain_slot[0]  = '0;
   assign chain_count[0] = '0;

   for (genvar r = 0; r < MAX_RESOURCES; r++) begin : g_cell
      logic [POOL_COUNT-1:0] cell_open;
      ffiga_cell #(
         .TIME_WIDTH (TIME_WIDTH),
         .SLOT_WIDTH (SLOT_WIDTH),
         .SLOT_NUM   (r + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_ctl    (chain_ctl[r]),
         .in_start  (chain_start[r]),
         .in_stop   (chain_stop[r]),
         .in_slot   (chain_slot[r]),
         .in_count  (chain_count[r]),
         .out_ctl   (chain_ctl[r+1]),
         .out_start (chain_start[r+1]),
         .out_stop  (chain_stop[r+1]),
         .out_slot  (chain_slot[r+1]),
         .out_count (chain_count[r+1]),
         .open_o    (cell_open)
      );
      assign open_pool0[r] = cell_open[0];
      assign open_pool1[r] = cell_open[1];
   end

   assign req_ready          = advance && !reset;
   assign rsp_valid          = tail.valid;
   assign rsp_pool_full      = !tail.done;
   assign rsp_assigned_index = tail.done ? INDEX_WIDTH'(chain_slot[MAX_RESOURCES]) : '0;
   assign rsp_served_count   = tail.done ? chain_count[MAX_RESOURCES] : '0;

   `ASSERT_CLK(a_full_zero, clock, reset,
      rsp_valid && rsp_pool_full |-> rsp_assigned_index == '0 && rsp_served_count == '0,
      "refused result carries a resource")
   `ASSERT_CLK(a_served_nonzero, clock, reset,
      rsp_valid && !rsp_pool_full |-> rsp_served_count != '0,
      "granted result has zero count")
   `ASSERT_ALWAYS(a_open_prefix, clock, reset,
      ((open_pool0 >> 1) & ~open_pool0) == '0 && ((open_pool1 >> 1) & ~open_pool1) == '0,
      "open resources not contiguous")

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import ffiga_pkg::*;

   localparam int SLOTS = DEF_MAX_RESOURCES;

   typedef struct {
      logic [INDEX_WIDTH-1:0] index;
      logic [COUNT_WIDTH-1:0] count;
      logic                   full;
   } grant_type;

   // first-fit predictor and store of grants still owed by the block
   class gate_ledger;
      logic [31:0]            slot_end    [POOL_COUNT][SLOTS];
      logic [COUNT_WIDTH-1:0] slot_served [POOL_COUNT][SLOTS];
      int                     open_count  [POOL_COUNT];
      grant_type              owed[$];
      int                     errors;
      int                     refusals;
      int                     saturated;
      int                     checked;

      function new();
         foreach (slot_served[p, r]) begin
            slot_served[p][r] = '0;
            slot_end[p][r]    = '0;
         end
         foreach (open_count[p]) open_count[p] = 0;
         errors    = 0;
         refusals  = 0;
         saturated = 0;
         checked   = 0;
      endfunction

      function void note_request(logic pool, logic [31:0] start_t, logic [31:0] end_t);
         int        slot;
         int        r;
         bit        hit;
         grant_type g;
         slot = 0;
         hit  = 0;
         for (r = 0; r < open_count[pool]; r++) begin
            if (!hit && start_t > slot_end[pool][r]) begin
               slot = r;
               hit  = 1;
            end
         end
         if (!hit && open_count[pool] < SLOTS) begin
            slot = open_count[pool];
            open_count[pool]++;
            hit = 1;
         end
         if (!hit) begin
            g.index = '0;
            g.count = '0;
            g.full  = 1'b1;
            refusals++;
         end else begin
            slot_end[pool][slot] = end_t;
            if (slot_served[pool][slot] != COUNT_MAX)
               slot_served[pool][slot] = slot_served[pool][slot] + COUNT_ONE;
            else
               saturated++;
            g.index = INDEX_WIDTH'(slot + 1);
            g.count = slot_served[pool][slot];
            g.full  = 1'b0;
         end
         owed.push_back(g);
      endfunction

      function void check_grant(logic [INDEX_WIDTH-1:0] index, logic [COUNT_WIDTH-1:0] count,
                                logic full);
         grant_type g;
         if (owed.size() == 0) begin
            $display("%0t: result transfer with no request waiting (index %0d count %0d full %0b)",
                     $time, index, count, full);
            errors++;
            return;
         end
         g = owed.pop_front();
         checked++;
         if (index !== g.index) begin
            $display("%0t: assigned_index expected %0d actual %0d", $time, g.index, index);
            errors++;
         end
         if (count !== g.count) begin
            $display("%0t: served_count expected %0d actual %0d", $time, g.count, count);
            errors++;
         end
         if (full !== g.full) begin
            $display("%0t: pool_full expected %0b actual %0b", $time, g.full, full);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_pool_select = 1'b0;
   logic [31:0]            req_start_time = '0;
   logic [31:0]            req_end_time = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [INDEX_WIDTH-1:0] rsp_assigned_index;
   logic [COUNT_WIDTH-1:0] rsp_served_count;
   logic                   rsp_pool_full;

   gate_ledger ledger;
   bit         calm = 1'b0;
   int         hold_asks = 0;

   first_fit_interval_gate_allocator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pool_select    (req_pool_select),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_served_count   (rsp_served_count),
      .rsp_pool_full      (rsp_pool_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // inputs only move at rising edges, so the falling edge sees what the next edge takes
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            ledger.check_grant(rsp_assigned_index, rsp_served_count, rsp_pool_full);
         if (req_valid && req_ready)
            ledger.note_request(req_pool_select, req_start_time, req_end_time);
      end
   end

   initial begin : receiver
      int stall_left;
      int hold_seen;
      stall_left = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   // called at a rising edge, returns at the rising edge of the transfer
   task automatic send_request(input logic pool, input logic [31:0] s, input logic [31:0] e);
      logic taken;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pool_select <= pool;
      req_start_time  <= s;
      req_end_time    <= e;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   initial begin
      #5_000_000;
      $display("[first_fit_interval_gate_allocator] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] cur [POOL_COUNT];
      logic [31:0] t;
      logic [31:0] s;
      logic [31:0] e;
      logic        p;
      logic        q;
      int          mode;
      int          len;
      int          step_hi;
      int          dur_lo;
      int          dur_hi;
      int          sent;
      ledger = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first class: opening, reuse, start equal to end, end before start
      send_request(1'b0, 32'h0, 32'h0);
      send_request(1'b0, 32'h0, 32'h5);
      send_request(1'b0, 32'h1, 32'h1);
      send_request(1'b0, 32'h5, 32'h9);
      send_request(1'b0, 32'h6, 32'h2);
      send_request(1'b0, 32'h3, 32'h7);
      send_request(1'b0, 32'hFFFF_FFFF, 32'h0);
      // second class: time extremes and alternating bit patterns
      send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_request(1'b1, 32'hFFFF_FFFF, 32'h0);
      send_request(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(1'b1, 32'h0, 32'hFFFF_FFFF);

      // same resource over and over, no idling
      calm = 1'b1;
      repeat (300) send_request(1'b0, 32'hFFFF_FFFF, 32'h0);
      calm = 1'b0;

      // overlapping requests until the second class runs out of resources
      repeat (64) send_request(1'b1, 32'h10, 32'h20);
      send_request(1'b1, 32'h18, 32'hFFFF_FFFF);

      // long receiver stall at the start of the random part
      hold_asks++;
      cur[0] = 32'h100;
      cur[1] = 32'h100;
      sent   = 0;
      while (sent < 1100) begin
         mode = $urandom_range(9);
         p    = $urandom_range(1);
         if (mode < 2) begin
            len = $urandom_range(80, 70); step_hi = 3;   dur_lo = 2000; dur_hi = 5000;
         end else if (mode < 6) begin
            len = $urandom_range(60, 20); step_hi = 40;  dur_lo = 50;   dur_hi = 1500;
         end else begin
            len = $urandom_range(40, 10); step_hi = 300; dur_lo = 0;    dur_hi = 250;
         end
         t = cur[p] + $urandom_range(100, 1);
         repeat (len) begin
            if ($urandom_range(9) == 0) begin
               q = $urandom_range(1);
               s = $urandom;
               e = $urandom_range(cur[q], 0);
               send_request(q, s, e);
            end else begin
               s = t;
               e = t + $urandom_range(dur_hi, dur_lo);
               send_request(p, s, e);
               if (e > cur[p]) cur[p] = e;
               t = t + $urandom_range(step_hi, 0);
            end
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (ledger.owed.size() != 0) @(posedge clock);
      repeat (3 * SLOTS) @(posedge clock);

      $display("checked %0d grants: %0d refused on a full pool, %0d at the count ceiling",
               ledger.checked, ledger.refusals, ledger.saturated);
      $display("random part: %0d sorted and unsorted interval requests over both pools", sent);
      if (ledger.errors == 0 && ledger.owed.size() == 0) begin
         $display("[first_fit_interval_gate_allocator] OK");
      end else begin
         $display("[first_fit_interval_gate_allocator] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
